// ===== sv/hop_pkg.sv =====
// ----------------------------------------------------------------------------
// Hopfield memory package
// Function codes, register indexes, field widths and the lane control type
// shared by the Hopfield associative memory modules.
// ----------------------------------------------------------------------------
package hop_pkg;

  localparam int PAT_W      = 16;
  localparam int CNT_W      = 8;
  localparam int NU_W       = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_RECALL = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEURONS_IN_USE = 8'd1;

  localparam logic [CNT_W-1:0] MAX_SWEEPS_RST     = 8'd32;
  localparam logic [NU_W-1:0]  NEURONS_IN_USE_RST = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_LIMIT        = 8'hFF;

  typedef struct packed {
    logic mul_en;
    logic active;
    logic bit_i;
    logic bit_j;
  } lane_ctrl_t;

endpackage

// ===== sv/hop_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module hop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/hop_lane.sv =====
// ----------------------------------------------------------------------------
// Hopfield weight lane
// Handles one column of a weight row: the saturating Hebbian update for a
// store, and the registered weight times state product for a recall.
// ----------------------------------------------------------------------------
module hop_lane #(
  parameter int WEIGHT_BITS = 10
) (
  input  logic                        clk,
  input  hop_pkg::lane_ctrl_t         ctrl,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  output logic signed [WEIGHT_BITS-1:0] weight_new,
  output logic                        clipped,
  output logic signed [WEIGHT_BITS:0]   prod
);

  import hop_pkg::*;

  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_ONE = {{(WEIGHT_BITS-1){1'b0}}, 1'b1};

  logic signed [WEIGHT_BITS:0] weight_ext;

  assign weight_ext = {weight[WEIGHT_BITS-1], weight};

  always_comb begin
    weight_new = weight;
    clipped    = 1'b0;
    if (ctrl.active) begin
      if (ctrl.bit_i == ctrl.bit_j) begin
        if (weight == W_MAX) begin
          clipped = 1'b1;
        end else begin
          weight_new = weight + W_ONE;
        end
      end else begin
        if (weight == W_MIN) begin
          clipped = 1'b1;
        end else begin
          weight_new = weight - W_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      if (!ctrl.active) begin
        prod <= '0;
      end else if (ctrl.bit_j) begin
        prod <= weight_ext;
      end else begin
        prod <= -weight_ext;
      end
    end
  end

endmodule

// ===== sv/hop_merge.sv =====
// ----------------------------------------------------------------------------
// Hopfield lane merge
// Adds the lane products in a balanced tree and then the probe term, takes the
// sign as the new neuron state, and gathers the lanes' clip flags.
// ----------------------------------------------------------------------------
module hop_merge #(
  parameter int NEURONS     = 16,
  parameter int WEIGHT_BITS = 10
) (
  input  logic signed [WEIGHT_BITS:0] prod [NEURONS],
  input  logic                        probe_bit,
  input  logic [NEURONS-1:0]          clipped,
  output logic                        new_bit,
  output logic                        any_clipped
);

  import hop_pkg::*;

  localparam int LEVELS = $clog2(NEURONS);
  localparam int PAD    = 1 << LEVELS;
  localparam int PW     = WEIGHT_BITS + 1;
  localparam int SUM_W  = PW + LEVELS + 1;

  localparam logic signed [SUM_W-1:0] PLUS_ONE  = {{(SUM_W-1){1'b0}}, 1'b1};
  localparam logic signed [SUM_W-1:0] MINUS_ONE = {SUM_W{1'b1}};

  logic signed [SUM_W-1:0] node [LEVELS+1][PAD];
  logic signed [SUM_W-1:0] total;

  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int k = 0; k < PAD; k++) begin
        node[l][k] = '0;
      end
    end
    for (int k = 0; k < NEURONS; k++) begin
      node[0][k] = {{(SUM_W-PW){prod[k][PW-1]}}, prod[k]};
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < PAD / 2; k++) begin
        if (k < (PAD >> (l + 1))) begin
          node[l+1][k] = node[l][2*k] + node[l][2*k+1];
        end
      end
    end
    total   = node[LEVELS][0] + (probe_bit ? PLUS_ONE : MINUS_ONE);
    new_bit = !total[SUM_W-1];
  end

  assign any_clipped = |clipped;

endmodule

// ===== sv/hopfield_associative_memory_top.sv =====
// ----------------------------------------------------------------------------
// Hopfield associative memory
// Bipolar Hopfield memory with Hebbian storage and neuron-serial recall.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+--------------------------------
//   cfg      | cfg_valid, cfg_ready       | cfg_index, cfg_data
//   item     | item_valid, item_stall     | func, pattern_bits
//   result   | result_valid, result_stall | state_bits, sweeps_used, converged,
//            |                            | patterns_stored, weight_saturated
//
// With n neurons in use, clear and the unused code go straight to the result
// register, store writes back the n weight rows (one weight row per cycle),
// and recall runs sweeps over the n neurons: each neuron update takes a weight row
// read followed by the lane products and the adder tree of the merge stage.
// Reset is synchronous; the weight rows carry valid bits that reset and clear
// drop all at once, so there is no clearing pass. item_stall is high from the
// acceptance of a request until its result is loaded. A new request is taken
// while a result waits under result_stall; a finished request waits only while
// the result register is still occupied.
// ----------------------------------------------------------------------------
module hopfield_associative_memory_top #(
  parameter int NEURONS     = 16,
  parameter int WEIGHT_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hop_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       func,
  input  logic [hop_pkg::PAT_W-1:0]        pattern_bits,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [hop_pkg::PAT_W-1:0]        state_bits,
  output logic [hop_pkg::CNT_W-1:0]        sweeps_used,
  output logic                             converged,
  output logic [hop_pkg::CNT_W-1:0]        patterns_stored,
  output logic                             weight_saturated
);

  import hop_pkg::*;

  localparam int IDX_W = $clog2(NEURONS);
  localparam int ROW_W = NEURONS * WEIGHT_BITS;
  localparam int PW    = WEIGHT_BITS + 1;

  localparam logic [NU_W-1:0]  NU_MAX  = NU_W'(NEURONS);
  localparam logic [NU_W-1:0]  NU_MIN  = 5'd2;
  localparam logic [NU_W-1:0]  NU_ONE  = 5'd1;
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ST_RD,
    S_ST_WR,
    S_RC_RD,
    S_RC_MUL,
    S_RC_SUM,
    S_FINISH
  } state_t;

  state_t state;

  logic [CNT_W-1:0]   max_sweeps;
  logic [NU_W-1:0]    neurons_in_use;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   n_last;
  logic [NEURONS-1:0] pat;
  logic [NEURONS-1:0] s;
  logic               changed;
  logic [CNT_W-1:0]   sweeps;
  logic               conv;
  logic [CNT_W-1:0]   stored_count;
  logic               sat_flag;
  logic [NEURONS-1:0] row_valid;
  logic               rd_valid;

  logic [IDX_W-1:0]   n_last_act;
  logic [NEURONS-1:0] pat_masked;
  logic [CNT_W-1:0]   cap;
  logic               flip;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ROW_W-1:0]   ram_rd_data;
  logic [ROW_W-1:0]   ram_wr_data;

  lane_ctrl_t                    lane_ctrl  [NEURONS];
  logic signed [WEIGHT_BITS-1:0] lane_w     [NEURONS];
  logic signed [WEIGHT_BITS-1:0] lane_w_new [NEURONS];
  logic signed [PW-1:0]          lane_prod  [NEURONS];
  logic [NEURONS-1:0]            lane_clip;
  logic                          new_bit;
  logic                          any_clipped;

  assign cfg_ready  = !rst;
  assign item_stall = rst || (state != S_IDLE);

  always_comb begin
    if (neurons_in_use < NU_MIN) begin
      n_last_act = IDX_ONE;
    end else if (neurons_in_use > NU_MAX) begin
      n_last_act = IDX_W'(NEURONS - 1);
    end else begin
      n_last_act = IDX_W'(neurons_in_use - NU_ONE);
    end
    for (int k = 0; k < NEURONS; k++) begin
      pat_masked[k] = pattern_bits[k] && (IDX_W'(k) <= n_last_act);
    end
  end

  assign cap  = (max_sweeps == '0) ? CNT_ONE : max_sweeps;
  assign flip = (new_bit != s[row]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sweeps     <= MAX_SWEEPS_RST;
      neurons_in_use <= NEURONS_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_SWEEPS:     max_sweeps     <= cfg_data;
        REG_NEURONS_IN_USE: neurons_in_use <= cfg_data[NU_W-1:0];
        default: ;
      endcase
    end
  end

  // Weight row addressing: the next row is fetched while the current one is
  // written back or summed.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = row;
    case (state)
      S_ST_RD, S_RC_RD: begin
        ram_rd_en = 1'b1;
      end
      S_ST_WR: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = row + IDX_ONE;
      end
      S_RC_SUM: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = (row == n_last) ? '0 : row + IDX_ONE;
      end
      default: ;
    endcase
  end

  assign ram_wr_en = (state == S_ST_WR);

  always_comb begin
    for (int j = 0; j < NEURONS; j++) begin
      lane_w[j]             = rd_valid ? ram_rd_data[j*WEIGHT_BITS +: WEIGHT_BITS] : '0;
      ram_wr_data[j*WEIGHT_BITS +: WEIGHT_BITS] = lane_w_new[j];
      lane_ctrl[j].mul_en   = (state == S_RC_MUL);
      lane_ctrl[j].active   = (IDX_W'(j) <= n_last) && (IDX_W'(j) != row);
      lane_ctrl[j].bit_i    = pat[row];
      lane_ctrl[j].bit_j    = (state == S_RC_MUL) ? s[j] : pat[j];
    end
  end

  hop_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NEURONS)
  ) u_weights (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (row),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  for (genvar j = 0; j < NEURONS; j++) begin : g_lane
    hop_lane #(
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_lane (
      .clk        (clk),
      .ctrl       (lane_ctrl[j]),
      .weight     (lane_w[j]),
      .weight_new (lane_w_new[j]),
      .clipped    (lane_clip[j]),
      .prod       (lane_prod[j])
    );
  end

  hop_merge #(
    .NEURONS     (NEURONS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_merge (
    .prod        (lane_prod),
    .probe_bit   (pat[row]),
    .clipped     (lane_clip),
    .new_bit     (new_bit),
    .any_clipped (any_clipped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      stored_count <= '0;
      sat_flag     <= 1'b0;
      row_valid    <= '0;
      rd_valid     <= 1'b0;
    end else begin
      if (ram_rd_en) begin
        rd_valid <= row_valid[ram_rd_addr];
      end
      if (result_valid && !result_stall && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            pat     <= pat_masked;
            s       <= (func_t'(func) == FUNC_RECALL) ? pat_masked : '0;
            n_last  <= n_last_act;
            row     <= '0;
            changed <= 1'b0;
            sweeps  <= '0;
            conv    <= 1'b0;
            case (func_t'(func))
              FUNC_CLEAR: begin
                row_valid    <= '0;
                stored_count <= '0;
                sat_flag     <= 1'b0;
                state        <= S_FINISH;
              end
              FUNC_STORE:  state <= S_ST_RD;
              FUNC_RECALL: state <= S_RC_RD;
              default:     state <= S_FINISH;
            endcase
          end
        end
        S_ST_RD: begin
          state <= S_ST_WR;
        end
        S_ST_WR: begin
          row_valid[row] <= 1'b1;
          if (any_clipped) begin
            sat_flag <= 1'b1;
          end
          if (row == n_last) begin
            if (stored_count != COUNT_LIMIT) begin
              stored_count <= stored_count + CNT_ONE;
            end
            state <= S_FINISH;
          end else begin
            row <= row + IDX_ONE;
          end
        end
        S_RC_RD: begin
          state <= S_RC_MUL;
        end
        S_RC_MUL: begin
          state <= S_RC_SUM;
        end
        S_RC_SUM: begin
          s[row] <= new_bit;
          if (row == n_last) begin
            sweeps <= sweeps + CNT_ONE;
            if (!(changed || flip)) begin
              conv  <= 1'b1;
              state <= S_FINISH;
            end else if (sweeps + CNT_ONE >= cap) begin
              state <= S_FINISH;
            end else begin
              row     <= '0;
              changed <= 1'b0;
              state   <= S_RC_MUL;
            end
          end else begin
            row     <= row + IDX_ONE;
            changed <= changed || flip;
            state   <= S_RC_MUL;
          end
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid     <= 1'b1;
            state_bits       <= PAT_W'(s);
            sweeps_used      <= sweeps;
            converged        <= conv;
            patterns_stored  <= stored_count;
            weight_saturated <= sat_flag;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A converged recall has run at least one sweep.
  a_conv_sweeps: assert property (@(posedge clk) disable iff (rst)
    result_valid && converged |-> sweeps_used != '0)
    else $error("converged result without any sweep");

  // Results without a sweep carry no neuron state.
  a_no_sweep_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sweeps_used == '0) |-> (state_bits == '0) && !converged)
    else $error("non-recall result carries recall fields");

  // The store walk never writes a row beyond the neurons in use.
  a_store_row: assert property (@(posedge clk) disable iff (rst)
    state == S_ST_WR |-> row <= n_last)
    else $error("store wrote a row outside the neurons in use");

endmodule
